>>> rtl/core/affinv_pkg.sv
// Shared constants and control type for the affine 2x3 inverse block.
`timescale 1ns / 1ps

package affinv_pkg;

  // Default fixed-point format: Q16.16 in a 32-bit word.
  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_FRAC_BITS = 16;

  // Six matrix entries travel in parallel lanes.
  localparam int NUM_LANES = 6;

  // Control that travels beside the data from the front end through every divider cell.
  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic [NUM_LANES-1:0] neg;
    logic [NUM_LANES-1:0] ovf;
  } ctl_t;

endpackage

>>> rtl/core/affine2d_inverse_top.sv
// Top level of the pipelined 2D affine matrix inverse.
`timescale 1ns / 1ps

// Inverts a 2x3 affine matrix given as two axis vectors and an offset in signed
// fixed point (Q16.16 by default, set by WORD_BITS and FRAC_BITS). The block is
// fully pipelined: while the output is not stalled it takes one transaction
// per clock and delivers one result per clock. Five front stages form the
// products, the exact determinant, the magnitudes and the divider setup; a
// chain of WORD_BITS divider cells then yields one quotient bit per cell for
// all six entries at once; a final register applies sign and saturation.
// Each quotient is truncated toward zero. A zero determinant returns success
// low with the input matrix echoed unchanged. Entries that fall outside the
// word range clamp to the nearest limit and raise saturated. Every stage
// holds its own valid bit, so a stall at the output fills bubbles upstream
// before it holds the input side.

module affine2d_inverse_top
  import affinv_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] axis_x_x,
  input  logic signed [WORD_BITS-1:0] axis_x_y,
  input  logic signed [WORD_BITS-1:0] axis_y_x,
  input  logic signed [WORD_BITS-1:0] axis_y_y,
  input  logic signed [WORD_BITS-1:0] offset_x,
  input  logic signed [WORD_BITS-1:0] offset_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] inv_axis_x_x,
  output logic signed [WORD_BITS-1:0] inv_axis_x_y,
  output logic signed [WORD_BITS-1:0] inv_axis_y_x,
  output logic signed [WORD_BITS-1:0] inv_axis_y_y,
  output logic signed [WORD_BITS-1:0] inv_offset_x,
  output logic signed [WORD_BITS-1:0] inv_offset_y,
  output logic                        success,
  output logic                        saturated
);

  localparam int W = WORD_BITS;

  // Link k feeds cell k; link 0 is the front end's output.
  ctl_t                          ctl  [W+1];
  logic [2*W-1:0]                den  [W+1];
  logic [NUM_LANES-1:0][2*W-1:0] rem  [W+1];
  logic [NUM_LANES-1:0][W-1:0]   sr   [W+1];
  logic [NUM_LANES-1:0][W-1:0]   echo [W+1];
  logic [W:0]                    rdy;

  logic                          front_ready;
  logic [NUM_LANES-1:0][W-1:0]   in_data;

  logic [NUM_LANES-1:0][W-1:0]   res_next;
  logic [NUM_LANES-1:0]          sat_next;
  logic [W-1:0]                  lim;
  logic [W-1:0]                  mag;
  logic                          neg;

  assign in_data  = {offset_y, offset_x, axis_y_y, axis_y_x, axis_x_y, axis_x_x};
  assign in_stall = !front_ready;

  affinv_front #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .up_ready (front_ready),
    .in_data  (in_data),
    .dn_ready (rdy[0]),
    .out_ctl  (ctl[0]),
    .out_den  (den[0]),
    .out_rem  (rem[0]),
    .out_sr   (sr[0]),
    .out_echo (echo[0])
  );

  for (genvar k = 0; k < W; k++) begin : g_cell
    affinv_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_ctl   (ctl[k]),
      .in_den   (den[k]),
      .in_rem   (rem[k]),
      .in_sr    (sr[k]),
      .in_echo  (echo[k]),
      .up_ready (rdy[k]),
      .dn_ready (rdy[k+1]),
      .out_ctl  (ctl[k+1]),
      .out_den  (den[k+1]),
      .out_rem  (rem[k+1]),
      .out_sr   (sr[k+1]),
      .out_echo (echo[k+1])
    );
  end

  // The output register takes a new result whenever it is empty or its
  // current result is being taken.
  assign rdy[W] = !out_valid || !out_stall;

  // After the last cell the shift register holds the low W quotient bits.
  // A negative result may reach one step further than a positive one.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      neg = ctl[W].neg[i] && (ctl[W].ovf[i] || (sr[W][i] != '0));
      lim = neg ? (W'(1) << (W-1)) : ((W'(1) << (W-1)) - W'(1));
      sat_next[i] = ctl[W].ovf[i] || (sr[W][i] > lim);
      mag = sat_next[i] ? lim : sr[W][i];
      res_next[i] = neg ? (~mag + W'(1)) : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy[W]) begin
      out_valid <= ctl[W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[W]) begin
      if (ctl[W].zero) begin
        inv_axis_x_x <= echo[W][0];
        inv_axis_x_y <= echo[W][1];
        inv_axis_y_x <= echo[W][2];
        inv_axis_y_y <= echo[W][3];
        inv_offset_x <= echo[W][4];
        inv_offset_y <= echo[W][5];
        success      <= 1'b0;
        saturated    <= 1'b0;
      end else begin
        inv_axis_x_x <= res_next[0];
        inv_axis_x_y <= res_next[1];
        inv_axis_y_x <= res_next[2];
        inv_axis_y_y <= res_next[3];
        inv_offset_x <= res_next[4];
        inv_offset_y <= res_next[5];
        success      <= 1'b1;
        saturated    <= |sat_next;
      end
    end
  end

endmodule

>>> rtl/core/affinv_front.sv
// Front end: products, determinant, magnitudes and divider setup.
`timescale 1ns / 1ps

module affinv_front
  import affinv_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   up_ready,
  input  logic [NUM_LANES-1:0][WORD_BITS-1:0]    in_data,
  input  logic                                   dn_ready,
  output ctl_t                                   out_ctl,
  output logic [2*WORD_BITS-1:0]                 out_den,
  output logic [NUM_LANES-1:0][2*WORD_BITS-1:0]  out_rem,
  output logic [NUM_LANES-1:0][WORD_BITS-1:0]    out_sr,
  output logic [NUM_LANES-1:0][WORD_BITS-1:0]    out_echo
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NB = ((W + 2*F) > (2*W + F)) ? (W + 2*F) : (2*W + F);
  localparam int CW = (NB > 3*W) ? NB : 3*W;

  logic [4:0] v;
  logic [5:0] r;

  logic [NUM_LANES-1:0][W-1:0]     x1;
  logic [NUM_LANES-1:0][2*W-1:0]   p2;
  logic [NUM_LANES-1:0][W-1:0]     e2;
  logic signed [2*W:0]             det3, nx3, ny3;
  logic [NUM_LANES-1:0][W-1:0]     e3;
  logic [2*W-1:0]                  den4;
  logic                            dneg4, zero4;
  logic [NUM_LANES-1:0][NB-1:0]    num4;
  logic [NUM_LANES-1:0]            nsgn4;
  logic [NUM_LANES-1:0][W-1:0]     e4;
  logic                            ctl_zero;
  logic [NUM_LANES-1:0]            ctl_neg;
  logic [NUM_LANES-1:0]            ctl_ovf;

  logic signed [W-1:0]   a, b, c, d, e, f;
  logic signed [2*W-1:0] pad, pbc, pcf, pde, pbe, paf;
  logic signed [2*W:0]   det_next, nx_next, ny_next;
  logic [NUM_LANES-1:0][NB-1:0] num_next;
  logic [NUM_LANES-1:0]         nsgn_next;
  logic [2*W-1:0]               den_next;
  logic [NUM_LANES-1:0]         ovf_next;
  logic [NUM_LANES-1:0][2*W-1:0] rem_next;

  function automatic logic [W-1:0] abs_w(input logic [W-1:0] x);
    abs_w = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [2*W-1:0] abs_2w(input logic [2*W:0] x);
    logic [2*W:0] t;
    t = x[2*W] ? (~x + 1'b1) : x;
    abs_2w = t[2*W-1:0];
  endfunction

  assign r[5] = dn_ready;
  for (genvar k = 0; k < 5; k++) begin : g_rdy
    assign r[k] = !v[k] || r[k+1];
  end
  assign up_ready = r[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (r[0]) v[0] <= in_valid;
      for (int k = 1; k < 5; k++) begin
        if (r[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage two: the six cross products.
  always_comb begin
    a = $signed(x1[0]);
    b = $signed(x1[1]);
    c = $signed(x1[2]);
    d = $signed(x1[3]);
    e = $signed(x1[4]);
    f = $signed(x1[5]);
    pad = a * d;
    pbc = b * c;
    pcf = c * f;
    pde = d * e;
    pbe = b * e;
    paf = a * f;
  end

  // Stage three: determinant and offset numerators.
  always_comb begin
    det_next = (2*W+1)'($signed(p2[0])) - (2*W+1)'($signed(p2[1]));
    nx_next  = (2*W+1)'($signed(p2[2])) - (2*W+1)'($signed(p2[3]));
    ny_next  = (2*W+1)'($signed(p2[4])) - (2*W+1)'($signed(p2[5]));
  end

  // Stage four: sign and magnitude, numerators scaled to the output format.
  always_comb begin
    den_next     = abs_2w(det3);
    num_next[0]  = NB'(abs_w(e3[3])) << (2*F);
    num_next[1]  = NB'(abs_w(e3[1])) << (2*F);
    num_next[2]  = NB'(abs_w(e3[2])) << (2*F);
    num_next[3]  = NB'(abs_w(e3[0])) << (2*F);
    num_next[4]  = NB'(abs_2w(nx3)) << F;
    num_next[5]  = NB'(abs_2w(ny3)) << F;
    nsgn_next[0] = e3[3][W-1];
    nsgn_next[1] = ~e3[1][W-1];
    nsgn_next[2] = ~e3[2][W-1];
    nsgn_next[3] = e3[0][W-1];
    nsgn_next[4] = nx3[2*W];
    nsgn_next[5] = ny3[2*W];
  end

  // Stage five: a quotient that needs more than W bits is flagged here, so the
  // divider cells only have to produce the low W quotient bits.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      ovf_next[i] = CW'(num4[i]) >= (CW'(den4) << W);
      rem_next[i] = (2*W)'(num4[i] >> W);
    end
  end

  always_ff @(posedge clk) begin
    if (r[0]) x1 <= in_data;
    if (r[1]) begin
      p2 <= {paf, pbe, pde, pcf, pbc, pad};
      e2 <= x1;
    end
    if (r[2]) begin
      det3 <= det_next;
      nx3  <= nx_next;
      ny3  <= ny_next;
      e3   <= e2;
    end
    if (r[3]) begin
      den4  <= den_next;
      dneg4 <= det3[2*W];
      zero4 <= (det3 == '0);
      num4  <= num_next;
      nsgn4 <= nsgn_next;
      e4    <= e3;
    end
    if (r[4]) begin
      out_den  <= den4;
      out_rem  <= rem_next;
      for (int i = 0; i < NUM_LANES; i++) begin
        out_sr[i] <= num4[i][W-1:0];
      end
      out_echo <= e4;
      ctl_zero <= zero4;
      ctl_neg  <= nsgn4 ^ {NUM_LANES{dneg4}};
      ctl_ovf  <= ovf_next;
    end
  end

  assign out_ctl = {v[4], ctl_zero, ctl_neg, ctl_ovf};

endmodule

>>> rtl/core/affinv_cell.sv
// One divider cell: produces one quotient bit in each of the six lanes.
`timescale 1ns / 1ps

module affinv_cell
  import affinv_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ctl_t                                   in_ctl,
  input  logic [2*WORD_BITS-1:0]                 in_den,
  input  logic [NUM_LANES-1:0][2*WORD_BITS-1:0]  in_rem,
  input  logic [NUM_LANES-1:0][WORD_BITS-1:0]    in_sr,
  input  logic [NUM_LANES-1:0][WORD_BITS-1:0]    in_echo,
  output logic                                   up_ready,
  input  logic                                   dn_ready,
  output ctl_t                                   out_ctl,
  output logic [2*WORD_BITS-1:0]                 out_den,
  output logic [NUM_LANES-1:0][2*WORD_BITS-1:0]  out_rem,
  output logic [NUM_LANES-1:0][WORD_BITS-1:0]    out_sr,
  output logic [NUM_LANES-1:0][WORD_BITS-1:0]    out_echo
);

  localparam int W = WORD_BITS;

  logic [NUM_LANES-1:0][2*W-1:0] rem_next;
  logic [NUM_LANES-1:0][W-1:0]   sr_next;
  logic [2*W:0]                  trial;
  logic                          vld;
  logic                          ctl_zero;
  logic [NUM_LANES-1:0]          ctl_neg;
  logic [NUM_LANES-1:0]          ctl_ovf;

  assign up_ready = !vld || dn_ready;

  // The numerator's next bit leaves the top of the shift register while the
  // new quotient bit enters at the bottom.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      trial = {in_rem[i], in_sr[i][W-1]};
      if (trial >= {1'b0, in_den}) begin
        rem_next[i] = (2*W)'(trial - {1'b0, in_den});
        sr_next[i]  = {in_sr[i][W-2:0], 1'b1};
      end else begin
        rem_next[i] = trial[2*W-1:0];
        sr_next[i]  = {in_sr[i][W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      ctl_zero     <= in_ctl.zero;
      ctl_neg      <= in_ctl.neg;
      ctl_ovf      <= in_ctl.ovf;
      out_den      <= in_den;
      out_rem      <= rem_next;
      out_sr       <= sr_next;
      out_echo     <= in_echo;
    end
  end

  assign out_ctl = {vld, ctl_zero, ctl_neg, ctl_ovf};

endmodule

>>> test/affinv_checker.sv
// Checker that predicts and compares the affine inverse results.
`timescale 1ns / 1ps

module affinv_checker #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] axis_x_x,
  input  logic signed [WORD_BITS-1:0] axis_x_y,
  input  logic signed [WORD_BITS-1:0] axis_y_x,
  input  logic signed [WORD_BITS-1:0] axis_y_y,
  input  logic signed [WORD_BITS-1:0] offset_x,
  input  logic signed [WORD_BITS-1:0] offset_y,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [WORD_BITS-1:0] inv_axis_x_x,
  input  logic signed [WORD_BITS-1:0] inv_axis_x_y,
  input  logic signed [WORD_BITS-1:0] inv_axis_y_x,
  input  logic signed [WORD_BITS-1:0] inv_axis_y_y,
  input  logic signed [WORD_BITS-1:0] inv_offset_x,
  input  logic signed [WORD_BITS-1:0] inv_offset_y,
  input  logic                        success,
  input  logic                        saturated,
  output int                          pending,
  output int                          errors
);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [159:0] wide_t;

  typedef struct {
    word_t m[6];
    logic  ok;
    logic  sat;
  } inverse_t;

  inverse_t inverse_q[$];

  // Exact quotient truncated toward zero, clamped to the word range.
  function automatic word_t clamp_div(wide_t num, wide_t den, ref logic sat);
    wide_t q;
    wide_t hi;
    wide_t lo;
    q  = num / den;
    hi = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
    lo = -(wide_t'(1) <<< (WORD_BITS - 1));
    if (q > hi) begin
      sat = 1'b1;
      return word_t'(hi);
    end
    if (q < lo) begin
      sat = 1'b1;
      return word_t'(lo);
    end
    return word_t'(q);
  endfunction

  function automatic inverse_t invert(word_t v[6]);
    inverse_t r;
    wide_t a, b, c, d, e, f, det, nx, ny;
    logic sat;
    a = v[0]; b = v[1]; c = v[2]; d = v[3]; e = v[4]; f = v[5];
    det = a * d - b * c;
    sat = 1'b0;
    if (det == 0) begin
      r.m = v;
      r.ok = 1'b0;
      r.sat = 1'b0;
      return r;
    end
    nx = c * f - d * e;
    ny = b * e - a * f;
    r.m[0] = clamp_div(d <<< (2 * FRAC_BITS), det, sat);
    r.m[1] = clamp_div((-b) <<< (2 * FRAC_BITS), det, sat);
    r.m[2] = clamp_div((-c) <<< (2 * FRAC_BITS), det, sat);
    r.m[3] = clamp_div(a <<< (2 * FRAC_BITS), det, sat);
    r.m[4] = clamp_div(nx <<< FRAC_BITS, det, sat);
    r.m[5] = clamp_div(ny <<< FRAC_BITS, det, sat);
    r.ok = 1'b1;
    r.sat = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    inverse_t want;
    word_t got[6];
    word_t v[6];
    if (rst) begin
      errors <= 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{inv_axis_x_x, inv_axis_x_y, inv_axis_y_x, inv_axis_y_y,
                inv_offset_x, inv_offset_y};
        if (inverse_q.size() == 0) begin
          if (errors < 10) $display("ERROR: result with no transaction pending");
          errors <= errors + 1;
        end else begin
          want = inverse_q.pop_front();
          if (got != want.m || success !== want.ok || saturated !== want.sat) begin
            if (errors < 10) begin
              $display("ERROR: expected %0d %0d %0d %0d %0d %0d ok=%0b sat=%0b",
                       want.m[0], want.m[1], want.m[2], want.m[3], want.m[4],
                       want.m[5], want.ok, want.sat);
              $display("       actual   %0d %0d %0d %0d %0d %0d ok=%0b sat=%0b",
                       got[0], got[1], got[2], got[3], got[4], got[5],
                       success, saturated);
            end
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        v = '{axis_x_x, axis_x_y, axis_y_x, axis_y_y, offset_x, offset_y};
        inverse_q.push_back(invert(v));
      end
      pending <= inverse_q.size();
    end
  end

endmodule

>>> test/tb_top.sv
// Testbench top: stimulus, flow control and verdict for the affine inverse.
`timescale 1ns / 1ps

module tb_top
  import affinv_pkg::*;
();

  localparam int WB = DEF_WORD_BITS;
  localparam int FB = DEF_FRAC_BITS;
  localparam int LATENCY = WB + 6;
  localparam int RANDOM_ITEMS = 800;

  typedef logic signed [WB-1:0] word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  word_t mat[6] = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  word_t inv[6];
  logic success;
  logic saturated;
  int pending;
  int errors;

  // Flow-control modes; calm is shared by the two sides.
  logic calm = 1'b0;           // no random idling on either side
  logic hold_out = 1'b0;       // receiver holds off for a long stretch
  logic done = 1'b0;

  always #4 clk = ~clk;

  affine2d_inverse_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .axis_x_x(mat[0]), .axis_x_y(mat[1]), .axis_y_x(mat[2]),
    .axis_y_y(mat[3]), .offset_x(mat[4]), .offset_y(mat[5]),
    .out_valid(out_valid), .out_stall(out_stall),
    .inv_axis_x_x(inv[0]), .inv_axis_x_y(inv[1]), .inv_axis_y_x(inv[2]),
    .inv_axis_y_y(inv[3]), .inv_offset_x(inv[4]), .inv_offset_y(inv[5]),
    .success(success), .saturated(saturated)
  );

  affinv_checker #(.WORD_BITS(WB), .FRAC_BITS(FB)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .axis_x_x(mat[0]), .axis_x_y(mat[1]), .axis_y_x(mat[2]),
    .axis_y_y(mat[3]), .offset_x(mat[4]), .offset_y(mat[5]),
    .out_valid(out_valid), .out_stall(out_stall),
    .inv_axis_x_x(inv[0]), .inv_axis_x_y(inv[1]), .inv_axis_y_x(inv[2]),
    .inv_axis_y_y(inv[3]), .inv_offset_x(inv[4]), .inv_offset_y(inv[5]),
    .success(success), .saturated(saturated),
    .pending(pending), .errors(errors)
  );

  // The receiver stalls at random about 37 times in a hundred unless the
  // test asks for a calm stretch or a long hold-off. Changes land on the
  // falling edge so the rising edge samples stable values.
  always @(negedge clk) begin
    if (hold_out) out_stall <= 1'b1;
    else if (calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 37);
  end

  // Picks a word that favors the extremes and small values, so that both
  // saturation and well-conditioned inverses appear often.
  function automatic word_t pick_word();
    case ($urandom_range(7))
      0: return word_t'($urandom_range(3)) - 2;
      1: return {1'b0, {(WB-1){1'b1}}};
      2: return {1'b1, {(WB-1){1'b0}}};
      3: return word_t'(signed'($urandom_range(1 << 20))) - (1 << 19);
      4: return word_t'(1 << FB);
      default: return word_t'($urandom());
    endcase
  endfunction

  // Offers one transaction and holds it until the block accepts it. Valid
  // stays high from one transaction to the next when there is no gap; the
  // caller lowers it once the last transaction has gone.
  task automatic send(input word_t a, b, c, d, e, f);
    int gap;
    if (!calm && $urandom_range(99) < 37) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    mat <= '{a, b, c, d, e, f};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random();
    word_t v[6];
    int s;
    foreach (v[i]) v[i] = pick_word();
    // About one in eight matrices is made singular on purpose: the second
    // axis is a multiple of the first, or one axis is zero.
    case ($urandom_range(15))
      0: begin
        s = $urandom_range(1, 5);
        v[2] = v[0] * s;
        v[3] = v[1] * s;
        if (v[0] != 0 && v[2] / s != v[0]) v[2] = v[0];
        if (v[1] != 0 && v[3] / s != v[1]) v[3] = v[1];
      end
      1: begin
        v[0] = '0;
        v[1] = '0;
      end
      default: ;
    endcase
    send(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  localparam word_t ONE  = word_t'(1 << FB);
  localparam word_t MAXW = {1'b0, {(WB-1){1'b1}}};
  localparam word_t MINW = {1'b1, {(WB-1){1'b0}}};

  initial begin
    int hold_cycles;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed matrices: identity, scaling, rotation, zero determinant with
    // the echo, tiny determinant that saturates, and the word extremes.
    calm <= 1'b1;
    send(ONE, 0, 0, ONE, 0, 0);
    send(ONE, 0, 0, ONE, MAXW, MINW);
    send(2 * ONE, 0, 0, ONE / 2, ONE * 3, -ONE);
    send(0, ONE, -ONE, 0, 5, -7);
    send(0, 0, 0, 0, 123, -456);
    send(ONE, ONE, ONE, ONE, MAXW, MINW);
    send(1, 0, 0, 1, 1, 1);
    send(1, 0, 0, -1, MINW, MAXW);
    send(MAXW, MAXW, MAXW, MAXW, MAXW, MAXW);
    send(MINW, MINW, MINW, MINW, MINW, MINW);
    send(MINW, 0, 0, MINW, MINW, MINW);
    send(MAXW, 0, 0, MINW, MAXW, MINW);
    send(MINW, MAXW, MAXW, MINW, 0, 0);
    send(-1, -1, 1, -1, -1, -1);
    send(MAXW, 1, 1, MAXW, MAXW, MINW);
    send(3, 0, 0, 7, 0, 1);
    send(ONE, 0, 0, 0, 9, 9);
    calm <= 1'b0;

    // Sender pauses until every result has arrived.
    drain();

    // Long receiver hold-off while the sender keeps offering, so the pipe
    // fills and the input stalls. A separate process counts the hold.
    calm <= 1'b1;
    hold_out <= 1'b1;
    fork
      begin
        hold_cycles = 0;
        while (hold_cycles < 3 * LATENCY) begin
          @(negedge clk);
          hold_cycles++;
        end
        hold_out <= 1'b0;
      end
      repeat (2 * LATENCY) send_random();
    join
    calm <= 1'b0;

    // Random traffic, with a calm stretch in the middle.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) calm <= 1'b1;
      if (n == RANDOM_ITEMS / 2) calm <= 1'b0;
      send_random();
    end
    drain();
    done <= 1'b1;
  end

  always @(posedge clk) begin
    if (done) begin
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
